// ===== src/htfa_pkg.sv =====
// Shared types and constants for the humidity/temperature frame averager.
// Used by htfa_ring and humidity_temp_frame_averager; depends on nothing.
`timescale 1ns / 1ps

package htfa_pkg;

  // Default window lengths
  localparam int TEMP_TAPS_DEF = 10;
  localparam int HUM_TAPS_DEF  = 40;

  // Width of one converted reading in hundredths
  localparam int VAL_W = 15;

  // Result queue behind the pipeline
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  // Conversion constants
  localparam logic [VAL_W-1:0] HUNDRED   = 15'd100;
  localparam logic [7:0]       DEC_LOW   = 8'd10;
  localparam logic [7:0]       DEC_HIGH  = 8'd100;
  localparam logic [15:0]      DIV10_MUL = 16'd205;  // d/10 == (d*205)>>11 for d < 1029

  // Configuration reset values
  localparam logic [14:0] TEMP_LIMIT_RST  = 15'd5000;
  localparam logic [14:0] HUM_LIMIT_RST   = 15'd9000;
  localparam logic [10:0] TEMP_OFFSET_RST = 11'd400;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_READ_FAIL = 2'd1,
    ST_CHECKSUM  = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    CFG_DECIMAL_MODE = 8'd0,
    CFG_TEMP_LIMIT   = 8'd1,
    CFG_HUM_LIMIT    = 8'd2,
    CFG_TEMP_OFFSET  = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       read_failed;
    logic [7:0] hum_integer;
    logic [7:0] hum_fraction;
    logic [7:0] temp_integer;
    logic [7:0] temp_fraction;
    logic [7:0] check_byte;
  } frame_t;

  typedef struct packed {
    logic [1:0]       frame_status;
    logic [VAL_W-1:0] temp_average;
    logic [VAL_W-1:0] hum_average;
    logic             temp_valid;
    logic             hum_valid;
    logic             any_valid;
    logic             sensor_seen;
  } result_t;

  // Per-beat control carried down the top-level pipeline
  typedef struct packed {
    logic    valid;
    status_t status;
    logic    t_ready;
    logic    h_ready;
    logic    alive;
  } stage_t;

  // Request into a ring: one new sample
  typedef struct packed {
    logic             wr;
    logic [VAL_W-1:0] value;
  } ring_req_t;

  // Status out of a ring: ready is for the sample in the request stage,
  // average belongs to the sample past the write, total and product registers
  typedef struct packed {
    logic             ready;
    logic [VAL_W-1:0] average;
  } ring_stat_t;

  // Decimal byte rescale: below 10 times ten, 100 and up divided by ten
  function automatic logic [6:0] rescale_decimal(input logic [7:0] d);
    logic [15:0] prod;
    logic [6:0]  res;
    prod = 16'(d) * DIV10_MUL;
    if (d < DEC_LOW) begin
      res = 7'(d) * 7'd10;
    end else if (d >= DEC_HIGH) begin
      res = 7'(prod[15:11]);
    end else begin
      res = d[6:0];
    end
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] to_hundredths(input logic [7:0] whole,
                                                     input logic [7:0] frac,
                                                     input logic       dec);
    logic [VAL_W-1:0] v;
    v = VAL_W'(whole) * HUNDRED;
    if (dec) begin
      v = v + VAL_W'(rescale_decimal(frac));
    end
    return v;
  endfunction

endpackage

// ===== src/htfa_ring.sv =====
// One boxcar window: ring memory, running total and divide by the tap count.
// Depends on htfa_pkg for the request and status structs.
`timescale 1ns / 1ps

module htfa_ring #(
  parameter int TAPS = htfa_pkg::TEMP_TAPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  htfa_pkg::ring_req_t req,
  output htfa_pkg::ring_stat_t stat
);

  localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int TOT_W  = htfa_pkg::VAL_W + $clog2(TAPS);
  localparam int Q_W    = TOT_W + 1;
  localparam int PROD_W = 2 * TOT_W + 1;
  localparam int SH     = TOT_W;
  localparam longint unsigned RECIP_L = (64'd1 << SH) / TAPS;
  localparam logic [TOT_W:0] RECIP = Q_W'(RECIP_L);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TAPS - 1);

  logic [htfa_pkg::VAL_W-1:0] mem [TAPS];

  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             ready_r, ready_nxt;
  logic             last;

  // request stage to write stage
  logic                       wr2_r;
  logic [IDX_W-1:0]           addr2_r;
  logic [htfa_pkg::VAL_W-1:0] val2_r;
  logic                       primed2_r;
  logic [htfa_pkg::VAL_W-1:0] rd_r;
  logic                       byp_r;
  logic [htfa_pkg::VAL_W-1:0] bypd_r;
  logic [htfa_pkg::VAL_W-1:0] old_val;

  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [TOT_W-1:0]  tot3_r;
  logic [Q_W-1:0]    q_est, rem, q_fix;

  // slot advance and first-wrap flag
  always_comb begin
    last      = (slot_r == LAST_SLOT);
    slot_nxt  = slot_r;
    ready_nxt = ready_r;
    if (req.wr) begin
      slot_nxt  = last ? '0 : slot_r + 1'b1;
      ready_nxt = ready_r | last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      ready_r <= 1'b0;
      wr2_r   <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      ready_r <= ready_nxt;
      wr2_r   <= req.wr;
    end
  end

  always_ff @(posedge clk) begin
    addr2_r   <= slot_r;
    val2_r    <= req.value;
    primed2_r <= ready_r;
  end

  // ring memory: write back in the second stage, read for the next sample;
  // a same-entry write in that edge is bypassed
  always_ff @(posedge clk) begin
    if (wr2_r) begin
      mem[addr2_r] <= val2_r;
    end
    rd_r   <= mem[slot_r];
    byp_r  <= wr2_r && (addr2_r == slot_r);
    bypd_r <= val2_r;
  end

  // entries not yet written since reset count as zero
  always_comb begin
    if (!primed2_r) begin
      old_val = '0;
    end else if (byp_r) begin
      old_val = bypd_r;
    end else begin
      old_val = rd_r;
    end
    total_nxt = total_r;
    if (wr2_r) begin
      total_nxt = total_r + TOT_W'(val2_r) - TOT_W'(old_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // divide by TAPS: reciprocal multiply, then one correction step
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(total_r) * PROD_W'(RECIP);
    tot3_r <= total_r;
  end

  always_comb begin
    q_est = prod_r[PROD_W-1:SH];
    rem   = Q_W'(tot3_r) - Q_W'(q_est * Q_W'(TAPS));
    q_fix = (rem >= Q_W'(TAPS)) ? q_est + 1'b1 : q_est;
  end

  assign stat.ready   = ready_nxt;
  assign stat.average = q_fix[htfa_pkg::VAL_W-1:0];

endmodule

// ===== src/humidity_temp_frame_averager.sv =====
// Top level of the humidity/temperature frame averager.
// Depends on htfa_pkg and instantiates htfa_ring for each window.
`timescale 1ns / 1ps

// Takes one five-byte sensor frame per beat, checks its additive checksum,
// converts good frames to hundredths (integer bytes only, or with rescaled
// decimal bytes when decimal_mode is set), clamps them and feeds a
// temperature and a humidity boxcar average; every frame yields exactly one
// result beat. A frame can be accepted every cycle while in_stall is low; each
// accepted frame passes the capture register, the ring read-modify-write (memory
// read, then write back and total update), the two-step constant divide and the
// result queue. Results wait in an 8-beat queue; in_stall rises only when 8 frames
// are outstanding. The ring memories need no clearing pass: entries read
// before a window first wraps are taken as zero. Configuration is written
// through cfg_valid/cfg_ready (always ready) and should only change while idle.

module humidity_temp_frame_averager #(
  parameter int TEMP_TAPS = htfa_pkg::TEMP_TAPS_DEF,
  parameter int HUM_TAPS  = htfa_pkg::HUM_TAPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  htfa_pkg::frame_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output htfa_pkg::result_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int VW = htfa_pkg::VAL_W;

  // configuration registers
  logic           decimal_mode_r;
  logic [14:0]    temp_limit_r;
  logic [14:0]    hum_limit_r;
  logic [10:0]    temp_offset_r;

  logic           in_accept, out_accept;
  logic           s1_valid_r;
  htfa_pkg::frame_t f1_r;

  logic [7:0]        sum8;
  htfa_pkg::status_t status1;
  logic              ok1;
  logic [VW-1:0]     t_raw, h_raw, t_val, h_val;
  logic              alive_r;

  htfa_pkg::stage_t     s2_nxt, s2_r, s3_r, s4_r;
  htfa_pkg::ring_req_t  t_req, h_req;
  htfa_pkg::ring_stat_t t_stat, h_stat;

  logic [VW-1:0]  t_held_r, t_held_nxt, h_held_r, h_held_nxt;
  logic           s4_ok;
  htfa_pkg::result_t res;

  htfa_pkg::result_t fifo_q [htfa_pkg::OUT_DEPTH];
  logic [htfa_pkg::OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [htfa_pkg::OUT_CNT_W-1:0] fifo_cnt_r, credit_r;

  assign cfg_ready  = 1'b1;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = (credit_r == htfa_pkg::OUT_CNT_W'(htfa_pkg::OUT_DEPTH));

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimal_mode_r <= 1'b0;
      temp_limit_r   <= htfa_pkg::TEMP_LIMIT_RST;
      hum_limit_r    <= htfa_pkg::HUM_LIMIT_RST;
      temp_offset_r  <= htfa_pkg::TEMP_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        htfa_pkg::CFG_DECIMAL_MODE: decimal_mode_r <= cfg_data[0];
        htfa_pkg::CFG_TEMP_LIMIT:   temp_limit_r   <= cfg_data[14:0];
        htfa_pkg::CFG_HUM_LIMIT:    hum_limit_r    <= cfg_data[14:0];
        htfa_pkg::CFG_TEMP_OFFSET:  temp_offset_r  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // frame capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      f1_r <= in_data;
    end
  end

  // check, convert and clamp
  always_comb begin
    sum8 = 8'(f1_r.hum_integer + f1_r.hum_fraction + f1_r.temp_integer
              + f1_r.temp_fraction);
    if (f1_r.read_failed) begin
      status1 = htfa_pkg::ST_READ_FAIL;
    end else if (sum8 != f1_r.check_byte) begin
      status1 = htfa_pkg::ST_CHECKSUM;
    end else begin
      status1 = htfa_pkg::ST_OK;
    end
    ok1   = s1_valid_r && (status1 == htfa_pkg::ST_OK);
    t_raw = htfa_pkg::to_hundredths(f1_r.temp_integer, f1_r.temp_fraction,
                                    decimal_mode_r);
    h_raw = htfa_pkg::to_hundredths(f1_r.hum_integer, f1_r.hum_fraction,
                                    decimal_mode_r);
    t_val = (t_raw > temp_limit_r) ? temp_limit_r : t_raw;
    h_val = (h_raw > hum_limit_r) ? hum_limit_r : h_raw;
  end

  assign t_req.wr    = ok1;
  assign t_req.value = t_val;
  assign h_req.wr    = ok1;
  assign h_req.value = h_val;

  htfa_ring #(.TAPS(TEMP_TAPS)) u_temp_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (t_req),
    .stat  (t_stat)
  );

  htfa_ring #(.TAPS(HUM_TAPS)) u_hum_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (h_req),
    .stat  (h_stat)
  );

  // flags are fixed in the first stage, then ride along with the beat
  always_comb begin
    s2_nxt.valid   = s1_valid_r;
    s2_nxt.status  = status1;
    s2_nxt.t_ready = t_stat.ready;
    s2_nxt.h_ready = h_stat.ready;
    s2_nxt.alive   = alive_r | ok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b0;
      s2_r    <= '0;
      s3_r    <= '0;
      s4_r    <= '0;
    end else begin
      alive_r <= alive_r | ok1;
      s2_r    <= s2_nxt;
      s3_r    <= s2_r;
      s4_r    <= s3_r;
    end
  end

  // publish averages and build the result beat
  always_comb begin
    s4_ok      = s4_r.valid && (s4_r.status == htfa_pkg::ST_OK);
    t_held_nxt = t_held_r;
    h_held_nxt = h_held_r;
    if (s4_ok && s4_r.t_ready) begin
      t_held_nxt = VW'(16'(t_stat.average) + 16'(temp_offset_r));
    end
    if (s4_ok && s4_r.h_ready) begin
      h_held_nxt = h_stat.average;
    end
    res.frame_status = s4_r.status;
    res.temp_average = t_held_nxt;
    res.hum_average  = h_held_nxt;
    res.temp_valid   = s4_r.t_ready;
    res.hum_valid    = s4_r.h_ready;
    res.any_valid    = s4_r.t_ready | s4_r.h_ready;
    res.sensor_seen  = s4_r.alive;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_held_r <= '0;
      h_held_r <= '0;
    end else begin
      t_held_r <= t_held_nxt;
      h_held_r <= h_held_nxt;
    end
  end

  // result queue and outstanding-beat count
  always_ff @(posedge clk) begin
    if (s4_r.valid) begin
      fifo_q[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      credit_r   <= '0;
    end else begin
      if (s4_r.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_accept) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + htfa_pkg::OUT_CNT_W'(s4_r.valid)
                    - htfa_pkg::OUT_CNT_W'(out_accept);
      credit_r   <= credit_r + htfa_pkg::OUT_CNT_W'(in_accept)
                    - htfa_pkg::OUT_CNT_W'(out_accept);
    end
  end

  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_q[rd_ptr_r];

  // checks
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= htfa_pkg::OUT_CNT_W'(htfa_pkg::OUT_DEPTH))
    else $error("outstanding beat count overflow");

  a_queue_le_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= credit_r)
    else $error("result queue holds more beats than were accepted");

  a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
    s4_r.valid |-> $past(in_accept, 4))
    else $error("result beat without a frame accepted four cycles earlier");

  a_valid_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.temp_valid || out_data.hum_valid) |-> out_data.sensor_seen)
    else $error("average reported valid before any good frame");

endmodule
